FILE: sv/fcm_pkg.sv
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types, constants and helpers for the chain manager: word layouts,
// table entry encoding, command and status codes, and the micro-op set that
// the controller issues to the datapath.
// ----------------------------------------------------------------------------
package fcm_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int PTR_W         = IDX_W + 1;      // can hold TABLE_ENTRIES itself

  // Field widths of the words on the ports
  localparam int CMD_W    = 3;
  localparam int BLK_W    = 12;
  localparam int CNT_W    = 12;
  localparam int STATUS_W = 2;
  localparam int FREED_W  = 13;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TRUNC  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WALK   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ENDED = 2'd2;

  // Table entry: a tag and, for a link, the next block
  typedef enum logic [1:0] {
    TAG_FREE = 2'd0,
    TAG_END  = 2'd1,
    TAG_LINK = 2'd2
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [IDX_W-1:0] link;
  } entry_t;

  // Input and result words
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [BLK_W-1:0] block_index;
    logic [CNT_W-1:0] link_count;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    result_block;
    logic [FREED_W-1:0]  freed_count;
  } out_item_t;

  // Datapath micro-ops, one per cycle
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_LOAD    = 3'd2,
    OP_SCAN    = 3'd3,
    OP_MARK    = 3'd4,
    OP_FOLLOW  = 3'd5,
    OP_RELEASE = 3'd6,
    OP_OUT     = 3'd7
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic             clr_last;
    logic             found;
    logic             exhausted;
    tag_t             rd_tag;
    logic             rem_zero;
    logic [CMD_W-1:0] cmd;
  } dp_sts_t;

  // A block index lies inside the table
  function automatic logic blk_in_range(logic [BLK_W-1:0] b);
    return (32'(b) < 32'(TABLE_ENTRIES));
  endfunction

endpackage

FILE: sv/fcm_ctrl.sv
// ----------------------------------------------------------------------------
// fcm_ctrl
// Sequencing state machine: clearing pass, command dispatch, free-entry scan,
// link following, chain release and result hand-off.
// ----------------------------------------------------------------------------
module fcm_ctrl
  import fcm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_sts_t  sts,
  output dp_op_t   op
);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_MARK    = 7'b0001000,
    S_FOLLOW  = 7'b0010000,
    S_RELEASE = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   blk_ok;

  assign blk_ok    = blk_in_range(in_item.block_index);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and micro-op
  always_comb begin
    state_nxt = state_r;
    op        = OP_NOP;
    unique case (state_r)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          case (in_item.command) inside
            CMD_ALLOC:           state_nxt = S_SCAN;
            CMD_APPEND:          state_nxt = blk_ok ? S_SCAN : S_DONE;
            CMD_FREE:            state_nxt = blk_ok ? S_RELEASE : S_DONE;
            CMD_TRUNC, CMD_WALK: state_nxt = blk_ok ? S_FOLLOW : S_DONE;
            default:             state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (sts.found) state_nxt = S_MARK;
        else if (sts.exhausted) state_nxt = S_DONE;
      end
      S_MARK: begin
        op        = OP_MARK;
        state_nxt = S_DONE;
      end
      S_FOLLOW: begin
        op = OP_FOLLOW;
        if (sts.rd_tag == TAG_FREE) begin
          state_nxt = S_DONE;
        end else if (sts.rem_zero) begin
          if (sts.cmd == CMD_TRUNC && sts.rd_tag == TAG_LINK) state_nxt = S_RELEASE;
          else state_nxt = S_DONE;
        end else if (sts.rd_tag != TAG_LINK) begin
          state_nxt = S_DONE;
        end
      end
      S_RELEASE: begin
        op = OP_RELEASE;
        if (sts.rd_tag != TAG_LINK) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // result word stays valid until taken
  assign out_valid_nxt = (op == OP_OUT) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/fcm_dpath.sv
// ----------------------------------------------------------------------------
// fcm_dpath
// Link table memory and the working registers: chain pointer, link counter,
// scan pointer, lowest-free hint, result fields and the output word register.
// ----------------------------------------------------------------------------
module fcm_dpath
  import fcm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dp_op_t    op,
  input  in_item_t  in_item,
  output dp_sts_t   sts,
  output out_item_t out_item
);

  // link table, one write and one registered read per cycle
  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // control registers
  logic [IDX_W-1:0] clr_ptr_r, clr_ptr_nxt;
  logic [PTR_W-1:0] hint_r, hint_nxt;        // every entry below is in use
  logic [PTR_W-1:0] scan_ptr_r, scan_ptr_nxt;
  logic             chk_v_r, chk_v_nxt;

  // payload registers
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [IDX_W-1:0]    chk_addr_r, chk_addr_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [BLK_W-1:0]    result_r, result_nxt;
  logic [PTR_W-1:0]    freed_r, freed_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic found, exhausted, in_ok;

  assign found     = chk_v_r && (rd_data_r.tag == TAG_FREE);
  assign exhausted = !chk_v_r && (scan_ptr_r == PTR_W'(TABLE_ENTRIES));
  assign in_ok     = blk_in_range(in_item.block_index);

  always_comb begin
    sts.clr_last  = (clr_ptr_r == IDX_W'(TABLE_ENTRIES - 1));
    sts.found     = found;
    sts.exhausted = exhausted;
    sts.rd_tag    = rd_data_r.tag;
    sts.rem_zero  = (rem_r == '0);
    sts.cmd       = cmd_r;
  end

  assign out_item = out_item_r;

  // micro-op decode
  always_comb begin
    clr_ptr_nxt  = clr_ptr_r;
    hint_nxt     = hint_r;
    scan_ptr_nxt = scan_ptr_r;
    chk_v_nxt    = chk_v_r;
    cmd_nxt      = cmd_r;
    cur_nxt      = cur_r;
    rem_nxt      = rem_r;
    chk_addr_nxt = chk_addr_r;
    slot_nxt     = slot_r;
    status_nxt   = status_r;
    result_nxt   = result_r;
    freed_nxt    = freed_r;
    out_item_nxt = out_item_r;
    rd_addr      = cur_r;
    wr_en        = 1'b0;
    wr_addr      = cur_r;
    wr_data      = '{tag: TAG_FREE, link: '0};

    unique case (op)
      OP_NOP: ;
      // sweep the table to all free after reset
      OP_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_ptr_r;
        clr_ptr_nxt = clr_ptr_r + IDX_W'(1);
      end
      // take the command word and read the head block
      OP_LOAD: begin
        cmd_nxt      = in_item.command;
        cur_nxt      = IDX_W'(in_item.block_index);
        rd_addr      = IDX_W'(in_item.block_index);
        rem_nxt      = in_item.link_count;
        scan_ptr_nxt = hint_r;
        chk_v_nxt    = 1'b0;
        result_nxt   = '0;
        freed_nxt    = '0;
        if (!in_ok && (in_item.command == CMD_APPEND || in_item.command == CMD_TRUNC ||
                       in_item.command == CMD_WALK))
          status_nxt = ST_ENDED;
        else
          status_nxt = ST_OK;
      end
      // pipelined search for the lowest free entry
      OP_SCAN: begin
        chk_addr_nxt = IDX_W'(scan_ptr_r);
        if (scan_ptr_r < PTR_W'(TABLE_ENTRIES)) begin
          rd_addr      = IDX_W'(scan_ptr_r);
          scan_ptr_nxt = scan_ptr_r + PTR_W'(1);
          chk_v_nxt    = 1'b1;
        end else begin
          chk_v_nxt = 1'b0;
        end
        if (found) begin
          slot_nxt   = chk_addr_r;
          result_nxt = BLK_W'(chk_addr_r);
          // append links the tail to the new block first
          if (cmd_r == CMD_APPEND) begin
            wr_en   = 1'b1;
            wr_addr = cur_r;
            wr_data = '{tag: TAG_LINK, link: chk_addr_r};
          end
        end else if (exhausted) begin
          status_nxt = ST_FULL;
        end
      end
      // claimed block becomes end of chain
      OP_MARK: begin
        wr_en    = 1'b1;
        wr_addr  = slot_r;
        wr_data  = '{tag: TAG_END, link: '0};
        hint_nxt = {1'b0, slot_r} + PTR_W'(1);
      end
      // one link per cycle for walk and truncate
      OP_FOLLOW: begin
        if (rd_data_r.tag == TAG_FREE) begin
          status_nxt = ST_ENDED;
        end else if (rem_r == '0) begin
          if (cmd_r == CMD_WALK) begin
            result_nxt = BLK_W'(cur_r);
          end else begin
            // cut the chain here, release continues from the old link
            wr_en   = 1'b1;
            wr_addr = cur_r;
            wr_data = '{tag: TAG_END, link: '0};
            cur_nxt = rd_data_r.link;
            rd_addr = rd_data_r.link;
          end
        end else if (rd_data_r.tag != TAG_LINK) begin
          status_nxt = ST_ENDED;
        end else begin
          cur_nxt = rd_data_r.link;
          rd_addr = rd_data_r.link;
          rem_nxt = rem_r - CNT_W'(1);
        end
      end
      // free one entry per cycle and move along the chain
      OP_RELEASE: begin
        if (rd_data_r.tag != TAG_FREE) begin
          wr_en     = 1'b1;
          wr_addr   = cur_r;
          freed_nxt = freed_r + PTR_W'(1);
          if ({1'b0, cur_r} < hint_r) hint_nxt = {1'b0, cur_r};
          cur_nxt   = rd_data_r.link;
          rd_addr   = rd_data_r.link;
        end
      end
      // load the result word
      OP_OUT: begin
        out_item_nxt.status       = status_r;
        out_item_nxt.result_block = result_r;
        out_item_nxt.freed_count  = FREED_W'(freed_r);
      end
      default: ;
    endcase
  end

  // memory: write-first so a read of the entry written this cycle sees new data
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (wr_en && (wr_addr == rd_addr)) rd_data_r <= wr_data;
    else rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r  <= '0;
      hint_r     <= '0;
      scan_ptr_r <= '0;
      chk_v_r    <= 1'b0;
    end else begin
      clr_ptr_r  <= clr_ptr_nxt;
      hint_r     <= hint_nxt;
      scan_ptr_r <= scan_ptr_nxt;
      chk_v_r    <= chk_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cur_r      <= cur_nxt;
    rem_r      <= rem_nxt;
    chk_addr_r <= chk_addr_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
    result_r   <= result_nxt;
    freed_r    <= freed_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

FILE: sv/fat_chain_manager_core.sv
// ----------------------------------------------------------------------------
// fat_chain_manager_core
// File allocation table chain manager: allocate, append, free, truncate and
// walk over a table of next-block links.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole table to free, one entry per cycle,
// and accepts no command word until that is done. Each command then takes
// one word in and gives one result word out, one command at a time; a new
// command is taken while the previous result still waits on out_stall. The
// table memory has one write port and one registered read port. Allocate
// and append scan from the lowest possibly free entry; walk and truncate
// follow the links, truncate then releasing the entries after the cut; free
// releases the chain from its head. A release stops after freeing the end
// entry or at a free entry. An unused command or an out-of-table index goes
// straight to the result word.
// ----------------------------------------------------------------------------
module fat_chain_manager_core
  import fcm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  dp_op_t  op;
  dp_sts_t sts;

  // sequencing
  fcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .op        (op)
  );

  // table and working registers
  fcm_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_item  (in_item),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule
